FILE: src/pps_pkg.sv
// Shared constants, payload types and control structs of the pulse peak and pedestal statistics.
package pps_pkg;

   // Fixed sample format and pedestal window
   localparam int CHANNELS    = 3;
   localparam int SAMPLE_BITS = 10;
   localparam int PED_LEN     = 10;
   localparam int RAW_W       = 16;
   localparam int IDX_W       = 8;
   localparam int CFG_W       = 8;
   localparam int REG_INDEX_W = 8;
   localparam int FRAC_BITS   = 4;

   // Accumulator widths follow from the window length and sample range
   localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
   localparam int SUM_W       = $clog2(PED_LEN * SAMPLE_MAX + 1);
   localparam int SQSUM_W     = $clog2(PED_LEN * SAMPLE_MAX * SAMPLE_MAX + 1);
   localparam int NSQ_W       = $clog2(PED_LEN * PED_LEN * SAMPLE_MAX * SAMPLE_MAX + 1);

   // Square root: radicand is 256 * (n*sumsq - sum^2), one root bit per step
   localparam int ROOT_W      = (NSQ_W + 2 * FRAC_BITS + 1) / 2;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int STEP_W      = $clog2(ROOT_W);

   // Result field widths
   localparam int MEAN_W      = 14;
   localparam int SIGMA_W     = 13;
   localparam int MEAN_NUM_W  = SUM_W + FRAC_BITS;

   // Division by PED_LEN as a multiply by a rounded-up reciprocal; exact below 2^22/PED_LEN
   localparam int DIV_SHIFT   = 22;
   localparam int RECIP       = ((1 << DIV_SHIFT) + PED_LEN - 1) / PED_LEN;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'(RECIP);

   // Register map
   localparam logic [REG_INDEX_W-1:0] REG_RECORD_LENGTH  = REG_INDEX_W'(0);
   localparam logic [REG_INDEX_W-1:0] REG_PEDESTAL_START = REG_INDEX_W'(1);
   localparam logic [CFG_W-1:0]       RECORD_LENGTH_RESET  = CFG_W'(50);
   localparam logic [CFG_W-1:0]       PEDESTAL_START_RESET = CFG_W'(10);

   typedef struct packed {
      logic             first_sample;
      logic [RAW_W-1:0] raw_sample_a;
      logic [RAW_W-1:0] raw_sample_b;
      logic [RAW_W-1:0] raw_sample_c;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] peak_value_a;
      logic [SAMPLE_BITS-1:0] peak_value_b;
      logic [SAMPLE_BITS-1:0] peak_value_c;
      logic [IDX_W-1:0]       peak_index_a;
      logic [IDX_W-1:0]       peak_index_b;
      logic [IDX_W-1:0]       peak_index_c;
      logic [MEAN_W-1:0]      ped_mean_a;
      logic [MEAN_W-1:0]      ped_mean_b;
      logic [MEAN_W-1:0]      ped_mean_c;
      logic [SIGMA_W-1:0]     ped_sigma_a;
      logic [SIGMA_W-1:0]     ped_sigma_b;
      logic [SIGMA_W-1:0]     ped_sigma_c;
   } rsp_payload_type;

   typedef struct packed {
      logic [REG_INDEX_W-1:0] reg_index;
      logic [CFG_W-1:0]       write_data;
   } csr_payload_type;

   // Per-sample control shared by all lanes
   typedef struct packed {
      logic             fire;
      logic             first;
      logic             in_window;
      logic             end_rec;
      logic [IDX_W-1:0] idx;
   } lane_ctl_type;

   // Running statistics of one channel
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] peak;
      logic [IDX_W-1:0]       peak_idx;
      logic [SUM_W-1:0]       sum;
      logic [SQSUM_W-1:0]     sqsum;
   } lane_stat_type;

   // Step strobes of the end-of-record sequencer
   typedef struct packed {
      logic load;
      logic square;
      logic radicand;
      logic root_step;
      logic scale;
   } fin_ctl_type;

   // Finished statistics of one channel
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] peak;
      logic [IDX_W-1:0]       peak_idx;
      logic [MEAN_W-1:0]      mean;
      logic [SIGMA_W-1:0]     sigma;
   } lane_res_type;

endpackage

FILE: src/pps_chan_if.sv
// Valid/ready channel interface carrying one payload struct.
interface pps_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/pps_lane.sv
// One channel lane: running peak with index, pedestal sum and sum of squares.
module pps_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  pps_pkg::lane_ctl_type   ctl,
   input  logic [pps_pkg::RAW_W-1:0] raw_sample,
   output pps_pkg::lane_stat_type  stat_next
);
   import pps_pkg::*;

   lane_stat_type            stat_ff;
   lane_stat_type            stat_in;
   lane_stat_type            base;
   logic [SAMPLE_BITS-1:0]   smp;
   logic [2*SAMPLE_BITS-1:0] smp_sq;

   assign smp    = raw_sample[SAMPLE_BITS-1:0];
   assign smp_sq = smp * smp;

   // Statistics including the current sample; a first sample starts from zero
   always_comb begin
      base      = ctl.first ? '0 : stat_ff;
      stat_next = base;
      if (smp > base.peak) begin
         stat_next.peak     = smp;
         stat_next.peak_idx = ctl.idx;
      end
      if (ctl.in_window) begin
         stat_next.sum   = base.sum + SUM_W'(smp);
         stat_next.sqsum = base.sqsum + SQSUM_W'(smp_sq);
      end
   end

   // Cleared after the last sample of a record, it has been handed to the finish unit
   assign stat_in = ctl.end_rec ? '0 : stat_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= '0;
      end else if (ctl.fire) begin
         stat_ff <= stat_in;
      end
   end

endmodule

FILE: src/pps_stat_unit.sv
// Per-channel finish unit: mean by reciprocal multiply, sigma by bit-serial square root.
module pps_stat_unit (
   input  logic                   clock,
   input  pps_pkg::fin_ctl_type   ctl,
   input  pps_pkg::lane_stat_type lane_next,
   output pps_pkg::lane_res_type  result
);
   import pps_pkg::*;

   logic [SAMPLE_BITS-1:0]        peak_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic [SUM_W-1:0]              sum_ff;
   logic [SQSUM_W-1:0]            sqsum_ff;
   logic [NSQ_W-1:0]              sq_ff;
   logic [NSQ_W-1:0]              nsq_ff;
   logic [MEAN_W-1:0]             mean_ff;
   logic [SIGMA_W-1:0]            sigma_ff;
   logic [RAD_W-1:0]              rem_ff;
   logic [RAD_W-1:0]              root_ff;
   logic [RAD_W-1:0]              bit_ff;

   logic [2*SUM_W-1:0]            sum_sq;
   logic [NSQ_W-1:0]              nsq_prod;
   logic [MEAN_NUM_W+RECIP_W-1:0] mean_prod;
   logic [ROOT_W+RECIP_W-1:0]     sigma_prod;
   logic [NSQ_W-1:0]              diff;
   logic [RAD_W:0]                trial;
   logic                          take;

   // Square step products
   assign sum_sq    = sum_ff * sum_ff;
   assign nsq_prod  = NSQ_W'(sqsum_ff) * NSQ_W'(PED_LEN);
   assign mean_prod = (MEAN_NUM_W+RECIP_W)'({sum_ff, {FRAC_BITS{1'b0}}})
                      * (MEAN_NUM_W+RECIP_W)'(RECIP_VAL);

   // Variance numerator, zero when not positive
   assign diff = (nsq_ff > sq_ff) ? (nsq_ff - sq_ff) : '0;

   // One root bit per step
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};
   assign take  = ({1'b0, rem_ff} >= trial);

   assign sigma_prod = (ROOT_W+RECIP_W)'(root_ff[ROOT_W-1:0])
                       * (ROOT_W+RECIP_W)'(RECIP_VAL);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         peak_ff  <= lane_next.peak;
         idx_ff   <= lane_next.peak_idx;
         sum_ff   <= lane_next.sum;
         sqsum_ff <= lane_next.sqsum;
      end
      if (ctl.square) begin
         sq_ff   <= NSQ_W'(sum_sq);
         nsq_ff  <= nsq_prod;
         mean_ff <= mean_prod[DIV_SHIFT +: MEAN_W];
      end
      if (ctl.radicand) begin
         rem_ff  <= RAD_W'({diff, {(2*FRAC_BITS){1'b0}}});
         root_ff <= '0;
         bit_ff  <= {2'b01, {(RAD_W-2){1'b0}}};
      end else if (ctl.root_step) begin
         if (take) begin
            rem_ff  <= rem_ff - trial[RAD_W-1:0];
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (ctl.scale) begin
         sigma_ff <= sigma_prod[DIV_SHIFT +: SIGMA_W];
      end
   end

   assign result.peak     = peak_ff;
   assign result.peak_idx = idx_ff;
   assign result.mean     = mean_ff;
   assign result.sigma    = sigma_ff;

endmodule

FILE: src/pps_merge.sv
// Merges the lane results into one response and holds it in the output register.
module pps_merge (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  pps_pkg::lane_res_type [pps_pkg::CHANNELS-1:0] results,
   output logic                                          slot_free,
   pps_chan_if.source                                    rsp_chan
);
   import pps_pkg::*;

   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic            rsp_valid_ff;

   // Gather the channels into the response fields
   always_comb begin
      rsp_in.peak_value_a = results[0].peak;
      rsp_in.peak_value_b = results[1].peak;
      rsp_in.peak_value_c = results[2].peak;
      rsp_in.peak_index_a = results[0].peak_idx;
      rsp_in.peak_index_b = results[1].peak_idx;
      rsp_in.peak_index_c = results[2].peak_idx;
      rsp_in.ped_mean_a   = results[0].mean;
      rsp_in.ped_mean_b   = results[1].mean;
      rsp_in.ped_mean_c   = results[2].mean;
      rsp_in.ped_sigma_a  = results[0].sigma;
      rsp_in.ped_sigma_b  = results[1].sigma;
      rsp_in.ped_sigma_c  = results[2].sigma;
   end

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

FILE: src/pulse_peak_and_pedestal_stats_top.sv
// Top level: sample counter, configuration, three channel lanes, finish sequencer and merge.
//
// Takes one three-channel sample word per clock, except while a record end waits for the
// finish units. Each channel lane tracks its peak and sums the pedestal window as the
// samples stream in, so inside a record every request is accepted without waiting. When
// the last sample of a record is accepted its statistics move to the per-channel finish
// units and the lanes start the next record at once. The finish runs square, radicand,
// 18 square-root steps at one root bit per cycle, scale, and hand-off to the output
// register once it is free; a request that would end another record waits until the
// finish is done and is taken in the cycle after. Results sit in an output register
// while the next record is accepted.
module pulse_peak_and_pedestal_stats_top (
   input  logic       clock,
   input  logic       reset,
   pps_chan_if.sink   req_chan,
   pps_chan_if.source rsp_chan,
   pps_chan_if.sink   csr_chan
);
   import pps_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SQUARE   = 3'd1;
   localparam logic [2:0] ST_RADICAND = 3'd2;
   localparam logic [2:0] ST_ROOT     = 3'd3;
   localparam logic [2:0] ST_SCALE    = 3'd4;
   localparam logic [2:0] ST_HOLD     = 3'd5;

   logic [CFG_W-1:0]  rec_len_ff;
   logic [CFG_W-1:0]  ped_start_ff;
   logic [IDX_W-1:0]  count_ff;
   logic [IDX_W-1:0]  count_in;
   logic [2:0]        state_ff;
   logic [2:0]        state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   logic              busy;
   logic              req_fire;
   logic              csr_fire;
   logic              slot_free;
   logic              out_load;
   logic [IDX_W:0]    win_lo;
   logic [IDX_W:0]    win_hi;
   lane_ctl_type      lane_ctl;
   fin_ctl_type       fin_ctl;
   logic [RAW_W-1:0]  raw_sample [CHANNELS];
   lane_stat_type     lane_next [CHANNELS];
   lane_res_type [CHANNELS-1:0] results;

   // Configuration writes
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_len_ff   <= RECORD_LENGTH_RESET;
         ped_start_ff <= PEDESTAL_START_RESET;
      end else if (csr_fire) begin
         unique case (csr_chan.payload.reg_index)
            REG_RECORD_LENGTH:  rec_len_ff   <= csr_chan.payload.write_data;
            REG_PEDESTAL_START: ped_start_ff <= csr_chan.payload.write_data;
            default: ;
         endcase
      end
   end

   // Sample index, window and end-of-record decode
   assign win_lo = {1'b0, ped_start_ff};
   assign win_hi = win_lo + (IDX_W+1)'(PED_LEN);

   always_comb begin
      lane_ctl.first     = req_chan.payload.first_sample;
      lane_ctl.idx       = req_chan.payload.first_sample ? '0 : count_ff;
      lane_ctl.in_window = ({1'b0, lane_ctl.idx} >= win_lo) && ({1'b0, lane_ctl.idx} < win_hi);
      lane_ctl.end_rec   = (lane_ctl.idx == rec_len_ff - IDX_W'(1));
      lane_ctl.fire      = req_fire;
   end

   // A record end waits for the finish units to be free
   assign busy           = (state_ff != ST_IDLE);
   assign req_chan.ready = !(busy && lane_ctl.end_rec);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign count_in = lane_ctl.end_rec ? '0 : lane_ctl.idx + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_fire) begin
         count_ff <= count_in;
      end
   end

   // Finish sequencer
   assign out_load = (state_ff == ST_HOLD) && slot_free;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && lane_ctl.end_rec) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_RADICAND;
         end
         ST_RADICAND: begin
            state_in = ST_ROOT;
            step_in  = '0;
         end
         ST_ROOT: begin
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = ST_SCALE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_SCALE: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      fin_ctl.load      = req_fire && lane_ctl.end_rec;
      fin_ctl.square    = (state_ff == ST_SQUARE);
      fin_ctl.radicand  = (state_ff == ST_RADICAND);
      fin_ctl.root_step = (state_ff == ST_ROOT);
      fin_ctl.scale     = (state_ff == ST_SCALE);
   end

   // Channel lanes and their finish units
   assign raw_sample[0] = req_chan.payload.raw_sample_a;
   assign raw_sample[1] = req_chan.payload.raw_sample_b;
   assign raw_sample[2] = req_chan.payload.raw_sample_c;

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      pps_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (lane_ctl),
         .raw_sample (raw_sample[ch]),
         .stat_next  (lane_next[ch])
      );

      pps_stat_unit u_stat (
         .clock     (clock),
         .ctl       (fin_ctl),
         .lane_next (lane_next[ch]),
         .result    (results[ch])
      );
   end

   pps_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .results   (results),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

   // Checks
   a_end_when_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && lane_ctl.end_rec) |-> (state_ff == ST_IDLE))
      else $error("record ended while finish units busy");

   a_end_starts_finish: assert property (@(posedge clock) disable iff (reset)
      (req_fire && lane_ctl.end_rec) |=> (state_ff == ST_SQUARE))
      else $error("record end did not start the finish sequence");

   a_rsp_after_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff == ST_HOLD))
      else $error("response raised without finished statistics");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (step_ff <= STEP_W'(ROOT_W - 1)))
      else $error("square root step count out of range");

endmodule

FILE: test/pps_stats_checker.sv
// Checker: predicts the per-record peak and pedestal statistics and compares each result.
module pps_stats_checker import pps_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  csr_payload_type csr_payload,
   output int              mismatch_count,
   output int              results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Configuration as the block should see it
   logic [CFG_W-1:0]       rec_len_cfg;
   logic [CFG_W-1:0]       ped_start_cfg;

   // Running record state: the sample index, and one entry per channel for the rest
   logic [IDX_W-1:0]       sample_idx;
   logic [SAMPLE_BITS-1:0] peak_val [CHANNELS];
   logic [IDX_W-1:0]       peak_at [CHANNELS];
   int unsigned            win_sum [CHANNELS];
   longint unsigned        win_sq_sum [CHANNELS];

   // Finished record statistics waiting for the block to deliver them
   rsp_payload_type        record_stats_q [$];

   initial mismatch_count = 0;
   initial results_pending = 0;

   task automatic clear_record();
      sample_idx = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         peak_val[ch]   = '0;
         peak_at[ch]    = '0;
         win_sum[ch]    = 0;
         win_sq_sum[ch] = 0;
      end
   endtask

   // Floor of the square root, one root bit at a time from the top
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 24; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // Fold one accepted request into the record; queue the statistics at its end
   task automatic take_sample(input req_payload_type r);
      logic [SAMPLE_BITS-1:0] s [CHANNELS];
      logic [IDX_W-1:0]       idx;
      bit                     in_win;
      longint unsigned        nsq;
      longint unsigned        sq;
      logic [MEAN_W-1:0]      mean [CHANNELS];
      logic [SIGMA_W-1:0]     sigma [CHANNELS];
      rsp_payload_type        stats;
      if (r.first_sample) clear_record();
      s[0] = r.raw_sample_a[SAMPLE_BITS-1:0];
      s[1] = r.raw_sample_b[SAMPLE_BITS-1:0];
      s[2] = r.raw_sample_c[SAMPLE_BITS-1:0];
      idx = sample_idx;
      // window is not cut by the 8-bit index, only by reaching it
      in_win = int'(idx) >= int'(ped_start_cfg) && int'(idx) < int'(ped_start_cfg) + PED_LEN;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (s[ch] > peak_val[ch]) begin
            peak_val[ch] = s[ch];
            peak_at[ch]  = idx;
         end
         if (in_win) begin
            win_sum[ch]    += s[ch];
            win_sq_sum[ch] += longint'(s[ch]) * longint'(s[ch]);
         end
      end
      // record length zero wraps to 256 samples
      if (idx != IDX_W'(rec_len_cfg - 1)) begin
         sample_idx = idx + 1'b1;
         return;
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
         nsq = longint'(PED_LEN) * win_sq_sum[ch];
         sq  = longint'(win_sum[ch]) * longint'(win_sum[ch]);
         mean[ch] = MEAN_W'((longint'(win_sum[ch]) * 16) / PED_LEN);
         // zero when the variance is not positive
         sigma[ch] = (nsq > sq) ? SIGMA_W'(floor_sqrt((nsq - sq) * 256) / PED_LEN) : '0;
      end
      stats.peak_value_a = peak_val[0];
      stats.peak_value_b = peak_val[1];
      stats.peak_value_c = peak_val[2];
      stats.peak_index_a = peak_at[0];
      stats.peak_index_b = peak_at[1];
      stats.peak_index_c = peak_at[2];
      stats.ped_mean_a   = mean[0];
      stats.ped_mean_b   = mean[1];
      stats.ped_mean_c   = mean[2];
      stats.ped_sigma_a  = sigma[0];
      stats.ped_sigma_b  = sigma[1];
      stats.ped_sigma_c  = sigma[2];
      record_stats_q.push_back(stats);
      clear_record();
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Results are matched before requests: a result never comes from a request of the same edge
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rec_len_cfg   = RECORD_LENGTH_RESET;
         ped_start_cfg = PEDESTAL_START_RESET;
         clear_record();
         record_stats_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_payload.reg_index)
               REG_RECORD_LENGTH:  rec_len_cfg   = csr_payload.write_data;
               REG_PEDESTAL_START: ped_start_cfg = csr_payload.write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (record_stats_q.size() == 0) begin
               $error("record statistics delivered with none expected");
               mismatch_count++;
            end else begin
               want = record_stats_q.pop_front();
               check_field("peak_value_a", want.peak_value_a, rsp_payload.peak_value_a);
               check_field("peak_value_b", want.peak_value_b, rsp_payload.peak_value_b);
               check_field("peak_value_c", want.peak_value_c, rsp_payload.peak_value_c);
               check_field("peak_index_a", want.peak_index_a, rsp_payload.peak_index_a);
               check_field("peak_index_b", want.peak_index_b, rsp_payload.peak_index_b);
               check_field("peak_index_c", want.peak_index_c, rsp_payload.peak_index_c);
               check_field("ped_mean_a", want.ped_mean_a, rsp_payload.ped_mean_a);
               check_field("ped_mean_b", want.ped_mean_b, rsp_payload.ped_mean_b);
               check_field("ped_mean_c", want.ped_mean_c, rsp_payload.ped_mean_c);
               check_field("ped_sigma_a", want.ped_sigma_a, rsp_payload.ped_sigma_a);
               check_field("ped_sigma_b", want.ped_sigma_b, rsp_payload.ped_sigma_b);
               check_field("ped_sigma_c", want.ped_sigma_c, rsp_payload.ped_sigma_c);
            end
         end
         if (req_valid && req_ready) take_sample(req_payload);
      end
      results_pending = record_stats_q.size();
   end

endmodule

FILE: test/tb_pulse_peak_and_pedestal_stats_top.sv
// Testbench top: clock, reset, sample stimulus, result stalls, configuration phases and verdict.
module tb_pulse_peak_and_pedestal_stats_top import pps_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int N_PHASES        = 11;
   localparam int HOLD_PHASE      = 2;

   logic clock;
   logic reset;

   pps_chan_if #(.payload_type(req_payload_type)) req_chan ();
   pps_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();
   pps_chan_if #(.payload_type(csr_payload_type)) csr_chan ();

   int mismatch_count;
   int results_pending;
   int burst_left = 0;
   int ped_level  = 100;
   int stall_cycles = 0;
   bit hold_off_req = 1'b0;

   // Per phase: record length, pedestal start, request budget
   int phase_len   [N_PHASES] = '{20, 1, 3, 10, 255, 0, 15, 50, 7, 32, 2};
   int phase_start [N_PHASES] = '{5, 0, 1, 0, 254, 250, 200, 10, 2, 22, 0};
   int phase_items [N_PHASES] = '{200, 120, 200, 200, 1, 1, 100, 150, 150, 160, 100};

   // Channel 0 words for the first directed record: extremes, masked-out bits, peak ties
   logic [RAW_W-1:0] extreme_words [8] = '{16'hFFFF, 16'h0000, 16'h03FF, 16'hFC00,
                                           16'h0001, 16'h03FE, 16'hFFFF, 16'h8000};

   pulse_peak_and_pedestal_stats_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pps_stats_checker stats_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_payload     (req_chan.payload),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_payload     (rsp_chan.payload),
      .csr_valid       (csr_chan.valid),
      .csr_ready       (csr_chan.ready),
      .csr_payload     (csr_chan.payload),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sample word: junk in the upper bits, value biased to zero, full scale and the pedestal
   function automatic logic [RAW_W-1:0] random_word();
      logic [SAMPLE_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = '0;
         1:       v = SAMPLE_BITS'(SAMPLE_MAX);
         2, 3, 4: v = SAMPLE_BITS'(ped_level + $urandom_range(0, 7));
         default: v = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      endcase
      return {(RAW_W - SAMPLE_BITS)'($urandom), v};
   endfunction

   // Offer one request and hold it until accepted; gaps fall between bursts
   task automatic send_sample(input bit first, input logic [RAW_W-1:0] a,
                              input logic [RAW_W-1:0] b, input logic [RAW_W-1:0] c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{first_sample: first, raw_sample_a: a, raw_sample_b: b,
                            raw_sample_c: c};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Both registers back to back; only called with nothing in flight
   task automatic write_config(input int rec_len, input int ped_start);
      csr_chan.valid   <= 1'b1;
      csr_chan.payload <= '{reg_index: REG_RECORD_LENGTH, write_data: CFG_W'(rec_len)};
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.payload <= '{reg_index: REG_PEDESTAL_START, write_data: CFG_W'(ped_start)};
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Stop sending, let every expected result out, then give the finish unit time to settle
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Whole records with random content; an occasional restart cuts a record short
   task automatic run_records(input int rec_len, input int budget);
      int  span;
      int  pos;
      int  sent;
      bit  first;
      span = (rec_len == 0) ? 256 : rec_len;
      pos  = 0;
      sent = 0;
      while (sent < budget || pos != 0) begin
         if (pos == 0) begin
            first     = $urandom_range(0, 1);
            ped_level = $urandom_range(0, SAMPLE_MAX - 8);
         end else begin
            first = ($urandom_range(0, 49) == 0);
         end
         if (first) pos = 0;
         send_sample(first, random_word(), random_word(), random_word());
         sent++;
         pos = (pos + 1 == span) ? 0 : pos + 1;
      end
   endtask

   // Result side: stall patterns that change now and then, plus one long hold-off on request
   initial begin
      int mode;
      int mode_left;
      int tick;
      mode = 0;
      mode_left = 0;
      tick = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= (tick % 5 != 0);
            endcase
         end
      end
   end

   // Watchdog: too long with no handshake on any channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("** pulse_peak_and_pedestal_stats_top: FAILED **");
         $finish;
      end
   end

   // Main sequence
   initial begin
      int i;
      int p;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: short records, window running past the record end
      write_config(8, 0);
      // channel 1 masked to zero throughout, channel 2 a ramp peaking on the last sample
      for (i = 0; i < 8; i++) begin
         send_sample(i == 0, extreme_words[i], 16'hFC00, RAW_W'(i * 146));
      end
      // next record starts without the first-sample flag, then restarts part way
      for (i = 0; i < 3; i++) begin
         send_sample(1'b0, random_word(), random_word(), random_word());
      end
      // constant nonzero window, pattern word, full-swing alternation
      for (i = 0; i < 8; i++) begin
         send_sample(i == 0, {(RAW_W - SAMPLE_BITS)'($urandom), SAMPLE_BITS'(512)}, 16'h5555,
                     i[0] ? 16'hFFFF : 16'h0000);
      end
      drain_results();

      // Random phases across record lengths and window positions
      for (p = 0; p < N_PHASES; p++) begin
         write_config(phase_len[p], phase_start[p]);
         if (p == HOLD_PHASE) hold_off_req = 1'b1;
         run_records(phase_len[p], phase_items[p]);
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("** pulse_peak_and_pedestal_stats_top: PASSED **");
      end else begin
         $display("** pulse_peak_and_pedestal_stats_top: FAILED **");
      end
      $finish;
   end

endmodule
